// ===== hdl/min_tracking_stack_macros.svh =====
// ----------------------------------------------------------------------------
// min_tracking_stack macros
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef MIN_TRACKING_STACK_MACROS_SVH
`define MIN_TRACKING_STACK_MACROS_SVH

// same-cycle implication, disabled during reset
`define MTS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define MTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/mts_pkg.sv =====
// ----------------------------------------------------------------------------
// mts_pkg
// Types, codes and defaults of the min-tracking stack.
// ----------------------------------------------------------------------------
package mts_pkg;

   localparam int DATA_W        = 32;
   localparam int COUNT_W       = 5;
   localparam int DEPTH_DEFAULT = 16;

   // operation codes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [1:0] ST_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic                     operation;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] popped_value;
      logic signed [DATA_W-1:0] top_value;
      logic signed [DATA_W-1:0] min_value;
      logic                     empty_res;
      logic [COUNT_W-1:0]       count;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;    // request word taken this cycle
      logic capture;   // RAM read data of a pop is valid
      logic load_rsp;  // load the result register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic pop_ok;    // request is a pop on a non-empty stack
   } sts_type;

endpackage

// ===== hdl/mts_ram.sv =====
// ----------------------------------------------------------------------------
// mts_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mts_ram #(
   parameter int WIDTH = mts_pkg::DATA_W,
   parameter int DEPTH = mts_pkg::DEPTH_DEFAULT,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/mts_ctrl.sv =====
// ----------------------------------------------------------------------------
// mts_ctrl
// Handshake control: accepts request words, sequences pops, owns rsp valid.
// ----------------------------------------------------------------------------
module mts_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mts_pkg::cmd_type cmd,
   input  mts_pkg::sts_type sts
);

   import mts_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_POP  = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      rsp_free;

   // result register is empty, or its word leaves this cycle
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !rsp_free;
   assign accept    = req_valid && !req_stall;

   assign cmd.accept   = accept;
   assign cmd.capture  = (state_ff == S_POP);
   assign cmd.load_rsp = (accept && !sts.pop_ok) || (state_ff == S_POP);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && sts.pop_ok) begin
               state_in = S_POP;
            end
         end
         S_POP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/mts_dp.sv =====
// ----------------------------------------------------------------------------
// mts_dp
// Stack datapath: value and minimum RAMs, counts, cached top and minimum.
// ----------------------------------------------------------------------------
module mts_dp #(
   parameter int DEPTH = mts_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  mts_pkg::req_type req_data,
   output mts_pkg::rsp_type rsp_data,
   input  mts_pkg::cmd_type cmd,
   output mts_pkg::sts_type sts
);

   import mts_pkg::*;

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         min_count_ff, min_count_in;
   logic signed [DATA_W-1:0] top_ff, top_in;
   logic signed [DATA_W-1:0] min_ff, min_in;
   logic signed [DATA_W-1:0] popped_ff, popped_in;
   logic                     min_pop_ff, min_pop_in;
   rsp_type                  rsp_ff, rsp_in;

   logic                     count_zero, full, min_none, is_pop;
   logic                     push_ok, pop_go, to_min, min_wr, min_pop;
   logic [CNT_W-1:0]         count_inc, count_dec, v_rd_idx, m_rd_idx;
   logic signed [DATA_W-1:0] cur_top, cur_min;
   logic [DATA_W-1:0]        v_rd_data, m_rd_data;

   assign count_zero = (count_ff == '0);
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign min_none   = count_zero || (min_count_ff == '0);
   assign cur_top    = count_zero ? '0 : top_ff;
   assign cur_min    = min_none ? '0 : min_ff;
   assign is_pop     = (req_data.operation == OP_POP);
   assign count_inc  = count_ff + CNT_W'(1);
   assign count_dec  = count_ff - CNT_W'(1);

   assign sts.pop_ok = is_pop && !count_zero;
   assign push_ok    = cmd.accept && !is_pop && !full;
   assign pop_go     = cmd.accept && sts.pop_ok;

   // ties go onto the minimum stack so duplicate minima survive pops
   assign to_min  = min_none || (req_data.value <= min_ff);
   assign min_wr  = push_ok && to_min && (min_count_ff < CNT_W'(DEPTH));
   assign min_pop = (min_count_ff != '0) && (top_ff == min_ff);

   // entries just below the current tops, read ahead for a pop
   assign v_rd_idx = count_ff - CNT_W'(2);
   assign m_rd_idx = min_count_ff - CNT_W'(2);

   mts_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (push_ok),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_data.value),
      .rd_addr (v_rd_idx[ADDR_W-1:0]),
      .rd_data (v_rd_data)
   );

   mts_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_min_ram (
      .clock   (clock),
      .wr_en   (min_wr),
      .wr_addr (min_count_ff[ADDR_W-1:0]),
      .wr_data (req_data.value),
      .rd_addr (m_rd_idx[ADDR_W-1:0]),
      .rd_data (m_rd_data)
   );

   always_comb begin
      count_in     = count_ff;
      min_count_in = min_count_ff;
      top_in       = top_ff;
      min_in       = min_ff;
      popped_in    = popped_ff;
      min_pop_in   = min_pop_ff;
      if (push_ok) begin
         count_in = count_inc;
         top_in   = req_data.value;
      end
      if (min_wr) begin
         min_count_in = min_count_ff + CNT_W'(1);
         min_in       = req_data.value;
      end
      if (pop_go) begin
         popped_in  = top_ff;
         min_pop_in = min_pop;
         count_in   = count_dec;
         if (count_dec == '0) begin
            min_count_in = '0;
         end else if (min_pop) begin
            min_count_in = min_count_ff - CNT_W'(1);
         end
      end
      if (cmd.capture) begin
         top_in = v_rd_data;
         if (min_pop_ff) begin
            min_in = m_rd_data;
         end
      end
   end

   always_comb begin
      rsp_in              = rsp_ff;
      rsp_in.popped_value = '0;
      if (cmd.capture) begin
         // count_ff already holds the post-pop count
         rsp_in.status       = ST_OK;
         rsp_in.popped_value = popped_ff;
         rsp_in.top_value    = count_zero ? '0 : v_rd_data;
         rsp_in.min_value    = min_none ? '0 : (min_pop_ff ? m_rd_data : min_ff);
         rsp_in.empty_res    = count_zero;
         rsp_in.count        = COUNT_W'(count_ff);
      end else if (is_pop) begin
         // only an underflow gets here
         rsp_in.status    = ST_UNDERFLOW;
         rsp_in.top_value = '0;
         rsp_in.min_value = '0;
         rsp_in.empty_res = 1'b1;
         rsp_in.count     = '0;
      end else if (full) begin
         rsp_in.status    = ST_OVERFLOW;
         rsp_in.top_value = cur_top;
         rsp_in.min_value = cur_min;
         rsp_in.empty_res = count_zero;
         rsp_in.count     = COUNT_W'(count_ff);
      end else begin
         rsp_in.status    = ST_OK;
         rsp_in.top_value = req_data.value;
         rsp_in.min_value = (to_min && (min_count_ff < CNT_W'(DEPTH))) ? req_data.value
                                                                       : cur_min;
         rsp_in.empty_res = 1'b0;
         rsp_in.count     = COUNT_W'(count_inc);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         min_count_ff <= '0;
      end else begin
         count_ff     <= count_in;
         min_count_ff <= min_count_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff     <= top_in;
      min_ff     <= min_in;
      popped_ff  <= popped_in;
      min_pop_ff <= min_pop_in;
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== hdl/min_tracking_stack.sv =====
// Push, overflow and underflow: the word is accepted and its result is registered at the end of the accepting cycle.
// Successful pop: the result is registered from S_POP, which waits on the registered read of the value and min RAMs.
// One word in flight; a new word is taken while the previous result is being drained.
// Reset (synchronous) clears the counts and handshake state; RAM contents are not cleared.
// ----------------------------------------------------------------------------
// min_tracking_stack
// Bounded LIFO of signed words with a shadow stack that tracks the minimum.
// ----------------------------------------------------------------------------
module min_tracking_stack #(
   parameter int DEPTH = mts_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mts_pkg::rsp_type rsp_data
);

   import mts_pkg::*;

   // Controller decides when a word is taken and when the result register
   // loads; the datapath holds all stack state and builds the result word.
   cmd_type cmd;
   sts_type sts;

   mts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Top and minimum are cached in registers so a push needs no RAM read;
   // a pop reads the entries below the tops in advance and refills them.
   mts_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .cmd      (cmd),
      .sts      (sts)
   );

endmodule

// ===== hdl/mts_checker.sv =====
// ----------------------------------------------------------------------------
// mts_checker
// Port-level checks of the min-tracking stack, bound to the top level.
// ----------------------------------------------------------------------------
`include "min_tracking_stack_macros.svh"

module mts_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input mts_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input mts_pkg::rsp_type rsp_data
);

   import mts_pkg::*;

   `MTS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result word changed")
   `MTS_ASSERT_NOW(a_empty_zero, clock, reset, rsp_valid && rsp_data.empty_res, (rsp_data.top_value == '0) && (rsp_data.min_value == '0) && (rsp_data.count == '0), "empty result with nonzero fields")
   `MTS_ASSERT_NOW(a_underflow, clock, reset, rsp_valid && (rsp_data.status == ST_UNDERFLOW), rsp_data.empty_res && (rsp_data.popped_value == '0), "underflow on a non-empty stack")
   `MTS_ASSERT_NOW(a_min_le_top, clock, reset, rsp_valid && !rsp_data.empty_res, rsp_data.min_value <= rsp_data.top_value, "minimum above top entry")

endmodule

bind min_tracking_stack mts_checker u_mts_checker (.*);
